// File: hdl/ledfd_pkg.sv
`timescale 1ns / 1ps

package ledfd_pkg;

  localparam int unsigned MaxPixels = 1024;
  localparam int unsigned PixW      = $clog2(MaxPixels);
  localparam int unsigned LimitW    = 11;
  localparam int unsigned AddrW     = 3;

  localparam logic [LimitW-1:0] PixelLimitReset = LimitW'(300);
  localparam logic [LimitW-1:0] MaxPixelsLim    = LimitW'(MaxPixels);

  localparam logic [7:0] ChrUpperA = 8'h41;  // 'A'
  localparam logic [7:0] ChrLowerD = 8'h64;  // 'd'
  localparam logic [7:0] ChrLowerA = 8'h61;  // 'a'
  localparam logic [7:0] ChrUpperP = 8'h50;  // 'P'
  localparam logic [7:0] ChrUpperI = 8'h49;  // 'I'
  localparam logic [7:0] ChrUpperN = 8'h4E;  // 'N'
  localparam logic [7:0] ChrUpperG = 8'h47;  // 'G'
  localparam logic [7:0] ChrLf     = 8'h0A;
  localparam logic [7:0] ChrSpace  = 8'h20;
  localparam logic [7:0] ChrTab    = 8'h09;
  localparam logic [7:0] ChrCr     = 8'h0D;
  localparam logic [7:0] ChkSalt   = 8'h55;

  localparam logic [2:0] PingDone = 3'd4;

  // register word index (paddr bit 2 upward)
  localparam logic [AddrW-3:0] RegPixelLimit = '0;

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_GOT_A,
    PH_GOT_D,
    PH_GOT_LA,
    PH_GOT_HI,
    PH_GOT_LO,
    PH_DATA,
    PH_PING
  } phase_e;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } channel_e;

  typedef enum logic {
    KIND_PIXEL,
    KIND_PING_ACK
  } kind_e;

  typedef struct packed {
    logic            valid;
    kind_e           kind;
    logic [PixW-1:0] index;
    logic [1:0]      channel;
    logic [7:0]      value;
    logic            last;
  } result_t;

  function automatic logic [7:0] ping_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = ChrUpperP;
      2'd1:    c = ChrUpperI;
      2'd2:    c = ChrUpperN;
      default: c = ChrUpperG;
    endcase
    return c;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == ChrSpace) || ((b >= ChrTab) && (b <= ChrCr));
  endfunction

endpackage

// File: hdl/ledfd_parser.sv
`timescale 1ns / 1ps

module ledfd_parser import ledfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic [LimitW-1:0] pixel_limit_i,
  output result_t           res_o
);

  phase_e            phase_q, phase_d;
  logic [7:0]        hi_q, hi_d;
  logic [7:0]        lo_q, lo_d;
  logic [PixW-1:0]   last_pix_q, last_pix_d;
  logic [PixW-1:0]   pix_q, pix_d;
  logic [1:0]        chan_q, chan_d;
  logic [2:0]        ping_q, ping_d;
  logic              spoil_q, spoil_d;

  logic [PixW-1:0]   lim_m1;
  logic [15:0]       count_raw;
  logic              data_last;

  // clamp the limit into 1..MaxPixels, kept as limit-1
  always_comb begin
    if (pixel_limit_i == '0) begin
      lim_m1 = '0;
    end else if (pixel_limit_i > MaxPixelsLim) begin
      lim_m1 = PixW'(MaxPixels - 1);
    end else begin
      lim_m1 = PixW'(pixel_limit_i - LimitW'(1));
    end
  end

  assign count_raw = {hi_q, lo_q};
  assign data_last = (pix_q == last_pix_q) && (chan_q == CH_BLUE);

  // next state
  always_comb begin
    phase_d    = phase_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    last_pix_d = last_pix_q;
    pix_d      = pix_q;
    chan_d     = chan_q;
    ping_d     = ping_q;
    spoil_d    = spoil_q;
    if (step_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (byte_i == ChrUpperA) begin
            phase_d = PH_GOT_A;
          end else if (byte_i == ChrUpperP) begin
            phase_d = PH_PING;
            ping_d  = 3'd1;
            spoil_d = 1'b0;
          end
        end
        PH_GOT_A: begin
          phase_d = (byte_i == ChrLowerD) ? PH_GOT_D : PH_HUNT;
        end
        PH_GOT_D: begin
          phase_d = (byte_i == ChrLowerA) ? PH_GOT_LA : PH_HUNT;
        end
        PH_GOT_LA: begin
          hi_d    = byte_i;
          phase_d = PH_GOT_HI;
        end
        PH_GOT_HI: begin
          lo_d    = byte_i;
          phase_d = PH_GOT_LO;
        end
        PH_GOT_LO: begin
          if (byte_i != (hi_q ^ lo_q ^ ChkSalt)) begin
            phase_d = PH_HUNT;
          end else begin
            // count = raw + 1 clamped to limit, stored as last pixel index
            last_pix_d = (count_raw > 16'(lim_m1)) ? lim_m1 : count_raw[PixW-1:0];
            pix_d      = '0;
            chan_d     = CH_RED;
            phase_d    = PH_DATA;
          end
        end
        PH_DATA: begin
          if (data_last) begin
            phase_d = PH_HUNT;
            pix_d   = '0;
            chan_d  = CH_RED;
          end else if (chan_q == CH_BLUE) begin
            pix_d  = pix_q + PixW'(1);
            chan_d = CH_RED;
          end else begin
            chan_d = chan_q + 2'd1;
          end
        end
        PH_PING: begin
          if (byte_i == ChrLf) begin
            phase_d = PH_HUNT;
            ping_d  = '0;
            spoil_d = 1'b0;
          end else if (ping_q < PingDone) begin
            if (byte_i == ping_char(ping_q[1:0])) begin
              ping_d = ping_q + 3'd1;
            end else begin
              spoil_d = 1'b1;
            end
          end else if (!is_blank(byte_i)) begin
            spoil_d = 1'b1;
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_o = '0;
    case (phase_q)
      PH_DATA: begin
        res_o.valid   = step_i;
        res_o.kind    = KIND_PIXEL;
        res_o.index   = pix_q;
        res_o.channel = chan_q;
        res_o.value   = byte_i;
        res_o.last    = data_last;
      end
      PH_PING: begin
        res_o.valid = step_i && (byte_i == ChrLf) && !spoil_q && (ping_q == PingDone);
        res_o.kind  = KIND_PING_ACK;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      hi_q       <= '0;
      lo_q       <= '0;
      last_pix_q <= '0;
      pix_q      <= '0;
      chan_q     <= '0;
      ping_q     <= '0;
      spoil_q    <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      hi_q       <= hi_d;
      lo_q       <= lo_d;
      last_pix_q <= last_pix_d;
      pix_q      <= pix_d;
      chan_q     <= chan_d;
      ping_q     <= ping_d;
      spoil_q    <= spoil_d;
    end
  end

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> chan_q != 2'd3)
    else $error("color channel out of range");

  a_pix_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> pix_q <= last_pix_q)
    else $error("pixel index ran past frame end");

  a_ping_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ping_q <= PingDone)
    else $error("ping progress overflow");

endmodule

// File: hdl/led_frame_deframer.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------------------
// in       | input     | in_valid_i/in_stall_o | rx_byte_i
// out      | output    | out_valid_o/out_stall_i | result_kind_o, pixel_index_o,
//          |           |                      | color_channel_o, pixel_value_o, frame_last_o
// cfg      | input     | APB psel/penable     | pixel_limit at address 0
//
// One byte per cycle sustained while out_stall_i stays low; a request passes an
// input register, then the header/ping parser, then the result register, which
// drives the outputs.
// Reset puts the parser in header hunt and pixel_limit back to 300.
// A stalled result holds the result register; one more byte waits in the input
// register, after which in_stall_o rises.

module led_frame_deframer import ledfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              result_kind_o,
  output logic [PixW-1:0]   pixel_index_o,
  output logic [1:0]        color_channel_o,
  output logic [7:0]        pixel_value_o,
  output logic              frame_last_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [LimitW-1:0] limit_q;
  logic              s1_valid_q;
  logic [7:0]        s1_byte_q;
  result_t           res;
  result_t           out_q;
  logic              out_free;
  logic              step;
  logic              in_accept;
  logic              reg_hit;

  // configuration
  assign pready  = 1'b1;
  assign reg_hit = (paddr[AddrW-1:2] == RegPixelLimit);
  assign prdata  = reg_hit ? 32'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= PixelLimitReset;
    end else if (psel && penable && pwrite && reg_hit) begin
      limit_q <= pwdata[LimitW-1:0];
    end
  end

  // pipeline control
  assign out_free   = !out_q.valid || !out_stall_i;
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  ledfd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .byte_i        (s1_byte_q),
    .pixel_limit_i (limit_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (out_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_q.valid;
  assign result_kind_o   = out_q.kind;
  assign pixel_index_o   = out_q.index;
  assign color_channel_o = out_q.channel;
  assign pixel_value_o   = out_q.value;
  assign frame_last_o    = out_q.last;

  a_ack_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_q.valid && out_q.kind == KIND_PING_ACK |->
      out_q.index == '0 && out_q.channel == '0 && out_q.value == '0 && !out_q.last)
    else $error("ping acknowledge carries pixel fields");

  a_hold_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_byte_q))
    else $error("pending byte lost while result stalled");

  a_no_step_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> step)
    else $error("result produced without a byte");

endmodule
